// File: sv/sld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sld_pkg;

   localparam int IQ_WIDTH_DEF  = 16;
   localparam int LLR_WIDTH_DEF = 16;
   localparam int NV_WIDTH      = 16;
   localparam int BPS_WIDTH     = 3;
   localparam int PT_WIDTH      = 14;
   localparam int NLANES        = 8;
   localparam int QDEPTH        = 2;
   localparam int DEN_WIDTH     = NV_WIDTH + 5;

   // constellation order codes of the mode register
   localparam logic [BPS_WIDTH-1:0] BPS_BPSK  = 3'd1;
   localparam logic [BPS_WIDTH-1:0] BPS_QPSK  = 3'd2;
   localparam logic [BPS_WIDTH-1:0] BPS_PSK8  = 3'd3;
   localparam logic [BPS_WIDTH-1:0] BPS_QAM16 = 3'd4;
   localparam logic [BPS_WIDTH-1:0] BPS_RESET = BPS_QPSK;

   // per-item control carried with the lane data through the queue
   typedef struct packed {
      logic [BPS_WIDTH-1:0] bps;
      logic [NV_WIDTH-1:0]  nv;
      logic                 sgn_i;
      logic                 sgn_q;
   } sld_ctrl_type;

   // 8-psk point of each gray label, in-phase
   function automatic logic signed [PT_WIDTH-1:0] psk_re(input logic [2:0] lane);
      logic signed [PT_WIDTH-1:0] r;
      case (lane)
         3'd0: r = 14'sd4096;
         3'd1: r = 14'sd2896;
         3'd2: r = -14'sd2896;
         3'd3: r = 14'sd0;
         3'd4: r = 14'sd2896;
         3'd5: r = 14'sd0;
         3'd6: r = -14'sd4096;
         default: r = -14'sd2896;
      endcase
      return r;
   endfunction

   // 8-psk point of each gray label, quadrature
   function automatic logic signed [PT_WIDTH-1:0] psk_im(input logic [2:0] lane);
      logic signed [PT_WIDTH-1:0] r;
      case (lane)
         3'd0: r = 14'sd0;
         3'd1: r = 14'sd2896;
         3'd2: r = 14'sd2896;
         3'd3: r = 14'sd4096;
         3'd4: r = -14'sd2896;
         3'd5: r = -14'sd4096;
         3'd6: r = 14'sd0;
         default: r = -14'sd2896;
      endcase
      return r;
   endfunction

   // 16-qam level of each gray half label
   function automatic logic signed [PT_WIDTH-1:0] qam_lvl(input logic [1:0] idx);
      logic signed [PT_WIDTH-1:0] r;
      case (idx)
         2'd0: r = -14'sd3886;
         2'd1: r = -14'sd1295;
         2'd2: r = 14'sd3886;
         default: r = 14'sd1295;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/sld_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface sld_req_if #(parameter int IQ_WIDTH = 16);
   logic                       valid;
   logic                       ready;
   logic signed [IQ_WIDTH-1:0] rx_i;
   logic signed [IQ_WIDTH-1:0] rx_q;
   logic [15:0]                nvar;
   modport source (output valid, rx_i, rx_q, nvar, input ready);
   modport sink (input valid, rx_i, rx_q, nvar, output ready);
endinterface

interface sld_rsp_if #(parameter int LLR_WIDTH = 16);
   logic                        valid;
   logic                        ready;
   logic signed [LLR_WIDTH-1:0] llr;
   logic [1:0]                  bit_position;
   logic                        last;
   modport source (output valid, llr, bit_position, last, input ready);
   modport sink (input valid, llr, bit_position, last, output ready);
endinterface
`default_nettype wire

// File: sv/soft_llr_demapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// soft bit demapper for one received i/q point per item
// req_ch carries rx_i, rx_q (signed, 12 fraction bits) and the noise variance
// (q4.12); rsp_ch carries one llr (q7.8, saturating) per symbol bit with its
// bit_position and a last flag on the final soft bit of the item.
// csr_we/csr_wdata write the constellation order: 1 bpsk, 2 qpsk,
// 3 gray 8-psk, 4 gray 16-qam; other codes consume the item with no result.
// pipeline: an item passes three distance stages, the item queue, three
// search stages, the divider load stage, one restoring divider stage per
// quotient bit and the output register.
// throughput: one soft bit per cycle at the output while the receiver is
// ready; the front takes a new item every cycle while the two-entry queue
// has room.
// reset clears the pipelines and the queue and sets the order to qpsk.
// when rsp_ch.ready is low the result holds and the back pipeline stalls;
// the front keeps taking items until the queue fills.
module soft_llr_demapper_top
   import sld_pkg::*;
#(
   parameter int IQ_WIDTH = IQ_WIDTH_DEF,
   parameter int LLR_WIDTH = LLR_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   sld_req_if.sink                   req_ch,
   sld_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [BPS_WIDTH-1:0] csr_wdata
);

   localparam int DI_W = ((IQ_WIDTH > 13) ? IQ_WIDTH : 13) + 1;
   localparam int NUM_W = 2 * DI_W + 1;
   localparam int DATA_W = (NLANES + 2) * NUM_W;

   logic              push_v, push_rdy, pop_v, pop;
   sld_ctrl_type      push_ctrl, pop_ctrl;
   logic [DATA_W-1:0] push_data, pop_data;

   // accept, classify and compute lane distances
   sld_front #(.IQ_WIDTH(IQ_WIDTH)) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .push_v(push_v), .push_ctrl(push_ctrl), .push_data(push_data),
      .push_rdy(push_rdy)
   );

   // decoupling queue
   sld_queue #(.DATA_W(DATA_W)) u_queue (
      .clock(clock), .reset(reset),
      .push_v(push_v), .push_ctrl(push_ctrl), .push_data(push_data),
      .push_rdy(push_rdy),
      .pop_v(pop_v), .pop_ctrl(pop_ctrl), .pop_data(pop_data), .pop(pop)
   );

   // per-bit search, division and output
   sld_back #(.IQ_WIDTH(IQ_WIDTH), .LLR_WIDTH(LLR_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .pop_v(pop_v), .pop_ctrl(pop_ctrl), .pop_data(pop_data), .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule
`default_nettype wire

// File: sv/sld_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sld_front
   import sld_pkg::*;
#(
   parameter int IQ_WIDTH = IQ_WIDTH_DEF,
   localparam int DI_W = ((IQ_WIDTH > 13) ? IQ_WIDTH : 13) + 1,
   localparam int SQ_W = 2 * DI_W,
   localparam int NUM_W = SQ_W + 1,
   localparam int DATA_W = (NLANES + 2) * NUM_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   sld_req_if.sink                req_ch,
   input  wire logic              csr_we,
   input  wire logic [BPS_WIDTH-1:0] csr_wdata,
   output logic                   push_v,
   output sld_ctrl_type           push_ctrl,
   output logic [DATA_W-1:0]      push_data,
   input  wire logic              push_rdy
);

   logic [BPS_WIDTH-1:0] bps_ff;

   logic                   s1_v_ff, s2_v_ff, s3_v_ff;
   sld_ctrl_type           s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff;
   sld_ctrl_type           s1_ctrl_in;
   logic signed [DI_W-1:0] s1_di_ff [NLANES];
   logic signed [DI_W-1:0] s1_dq_ff [NLANES];
   logic signed [DI_W-1:0] s1_di_in [NLANES];
   logic signed [DI_W-1:0] s1_dq_in [NLANES];
   logic [SQ_W-1:0]        s2_si_ff [NLANES];
   logic [SQ_W-1:0]        s2_sq_ff [NLANES];
   logic [NUM_W-1:0]       s3_e_ff [NLANES];
   logic [NUM_W-1:0]       s1_li_ff, s1_lq_ff, s2_li_ff, s2_lq_ff, s3_li_ff, s3_lq_ff;
   logic [NUM_W-1:0]       s1_li_in, s1_lq_in;
   logic [IQ_WIDTH-1:0]    mag_i, mag_q;
   logic signed [DI_W-1:0] xi_x, xq_x;
   logic                   s1_v_in;
   logic                   f_adv;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff <= BPS_RESET;
      end else if (csr_we) begin
         bps_ff <= csr_wdata;
      end
   end

   assign f_adv = !s3_v_ff || push_rdy;
   assign req_ch.ready = f_adv;

   // classify: orders outside the supported set make no results and are dropped
   always_comb begin
      s1_v_in = req_ch.valid && (bps_ff == BPS_BPSK || bps_ff == BPS_QPSK ||
                                 bps_ff == BPS_PSK8 || bps_ff == BPS_QAM16);
      s1_ctrl_in.bps   = bps_ff;
      s1_ctrl_in.nv    = (req_ch.nvar == '0) ? NV_WIDTH'(1) : req_ch.nvar;
      s1_ctrl_in.sgn_i = req_ch.rx_i[IQ_WIDTH-1];
      s1_ctrl_in.sgn_q = req_ch.rx_q[IQ_WIDTH-1];
   end

   // linear numerators 512*|x|
   always_comb begin
      mag_i = req_ch.rx_i[IQ_WIDTH-1] ? IQ_WIDTH'(-req_ch.rx_i) : IQ_WIDTH'(req_ch.rx_i);
      mag_q = req_ch.rx_q[IQ_WIDTH-1] ? IQ_WIDTH'(-req_ch.rx_q) : IQ_WIDTH'(req_ch.rx_q);
      s1_li_in = NUM_W'({mag_i, 9'b0});
      s1_lq_in = NUM_W'({mag_q, 9'b0});
   end

   // per-lane offsets to the constellation points
   always_comb begin
      logic [2:0] lane;
      xi_x = DI_W'(req_ch.rx_i);
      xq_x = DI_W'(req_ch.rx_q);
      for (int l = 0; l < NLANES; l++) begin
         lane = 3'(l);
         if (bps_ff == BPS_QAM16) begin
            if (!lane[2]) begin
               s1_di_in[l] = xi_x - DI_W'(qam_lvl(lane[1:0]));
               s1_dq_in[l] = '0;
            end else begin
               s1_di_in[l] = '0;
               s1_dq_in[l] = xq_x - DI_W'(qam_lvl(lane[1:0]));
            end
         end else begin
            s1_di_in[l] = xi_x - DI_W'(psk_re(lane));
            s1_dq_in[l] = xq_x - DI_W'(psk_im(lane));
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (f_adv) begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // offsets, squares, distance sums
   always_ff @(posedge clock) begin
      if (f_adv) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_li_ff   <= s1_li_in;
         s1_lq_ff   <= s1_lq_in;
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_li_ff   <= s1_li_ff;
         s2_lq_ff   <= s1_lq_ff;
         s3_ctrl_ff <= s2_ctrl_ff;
         s3_li_ff   <= s2_li_ff;
         s3_lq_ff   <= s2_lq_ff;
         for (int l = 0; l < NLANES; l++) begin
            s1_di_ff[l] <= s1_di_in[l];
            s1_dq_ff[l] <= s1_dq_in[l];
            s2_si_ff[l] <= SQ_W'(s1_di_ff[l] * s1_di_ff[l]);
            s2_sq_ff[l] <= SQ_W'(s1_dq_ff[l] * s1_dq_ff[l]);
            s3_e_ff[l]  <= NUM_W'(s2_si_ff[l]) + NUM_W'(s2_sq_ff[l]);
         end
      end
   end

   // pack for the queue
   always_comb begin
      push_v    = s3_v_ff;
      push_ctrl = s3_ctrl_ff;
      for (int l = 0; l < NLANES; l++) begin
         push_data[l*NUM_W +: NUM_W] = s3_e_ff[l];
      end
      push_data[NLANES*NUM_W +: NUM_W]     = s3_li_ff;
      push_data[(NLANES+1)*NUM_W +: NUM_W] = s3_lq_ff;
   end

endmodule
`default_nettype wire

// File: sv/sld_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sld_queue
   import sld_pkg::*;
#(
   parameter int DATA_W = 340
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_v,
   input  sld_ctrl_type           push_ctrl,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   push_rdy,
   output logic                   pop_v,
   output sld_ctrl_type           pop_ctrl,
   output logic [DATA_W-1:0]      pop_data,
   input  wire logic              pop
);

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   sld_ctrl_type      ctrl_ff [QDEPTH];
   logic [DATA_W-1:0] data_ff [QDEPTH];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              do_push, do_pop;

   assign push_rdy = (cnt_ff != CNT_W'(QDEPTH));
   assign pop_v    = (cnt_ff != '0);
   assign do_push  = push_v && push_rdy;
   assign do_pop   = pop && pop_v;
   assign pop_ctrl = ctrl_ff[rd_ff];
   assign pop_data = data_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ctrl_ff[wr_ff] <= push_ctrl;
         data_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: sv/sld_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sld_back
   import sld_pkg::*;
#(
   parameter int IQ_WIDTH = IQ_WIDTH_DEF,
   parameter int LLR_WIDTH = LLR_WIDTH_DEF,
   localparam int DI_W = ((IQ_WIDTH > 13) ? IQ_WIDTH : 13) + 1,
   localparam int NUM_W = 2 * DI_W + 1,
   localparam int DATA_W = (NLANES + 2) * NUM_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_v,
   input  sld_ctrl_type           pop_ctrl,
   input  wire logic [DATA_W-1:0] pop_data,
   output logic                   pop,
   sld_rsp_if.source              rsp_ch
);

   localparam int QB = LLR_WIDTH;
   localparam int NW = NUM_W + 1;
   localparam int CW = ((NW > DEN_WIDTH + QB) ? NW : DEN_WIDTH + QB) + 1;

   logic adv;

   // sequencer over the bits of the head item
   logic [1:0]       bidx_ff;
   logic             last_now;
   logic             is_lin;
   logic [1:0]       pos_now;
   logic [NUM_W-1:0] e [NLANES];
   logic [NLANES-1:0] inc, cls;

   // search and setup stages
   logic             b1_v_ff, b2_v_ff, b3_v_ff;
   logic             b1_lin_ff, b2_lin_ff;
   logic [1:0]       b1_pos_ff, b2_pos_ff, b3_pos_ff;
   logic             b1_last_ff, b2_last_ff, b3_last_ff;
   logic             b1_neg_ff, b2_neg_ff, b3_neg_ff;
   logic [NUM_W-1:0] b1_ln_ff, b2_ln_ff, b3_num_ff;
   logic [DEN_WIDTH-1:0] b1_den_ff, b2_den_ff, b3_den_ff;
   logic [NUM_W-1:0] b1_m0lo_ff, b1_m1lo_ff, b1_m0hi_ff, b1_m1hi_ff;
   logic [NUM_W-1:0] m0lo_in, m1lo_in, m0hi_in, m1hi_in;
   logic [NUM_W-1:0] b2_m0_ff, b2_m1_ff;
   logic [NUM_W-1:0] b1_ln_in;
   logic             b1_neg_in;
   logic [DEN_WIDTH-1:0] b1_den_in;

   // divider stages
   logic             dv_v_ff    [QB+1];
   logic [CW-1:0]    dv_r_ff    [QB+1];
   logic [QB-1:0]    dv_q_ff    [QB+1];
   logic [DEN_WIDTH-1:0] dv_den_ff [QB+1];
   logic             dv_neg_ff  [QB+1];
   logic [1:0]       dv_pos_ff  [QB+1];
   logic             dv_last_ff [QB+1];
   logic             dv_sat_ff  [QB+1];
   logic [CW-1:0]    dv_r_in    [QB];
   logic [QB-1:0]    dv_q_in    [QB];
   logic             dv_sat_in  [QB];

   // output register
   logic                 out_v_ff;
   logic [LLR_WIDTH-1:0] out_llr_ff, out_llr_in;
   logic [1:0]           out_pos_ff;
   logic                 out_last_ff;

   assign adv = !out_v_ff || rsp_ch.ready;

   // head item decode
   always_comb begin
      for (int l = 0; l < NLANES; l++) begin
         e[l] = pop_data[l*NUM_W +: NUM_W];
      end
      is_lin   = (pop_ctrl.bps == BPS_BPSK) || (pop_ctrl.bps == BPS_QPSK);
      last_now = ({1'b0, bidx_ff} == (pop_ctrl.bps - 3'd1));
      pos_now  = is_lin ? bidx_ff : 2'(pop_ctrl.bps - 3'd1 - {1'b0, bidx_ff});
      pop      = pop_v && adv && last_now;
   end

   // lane classes for the current bit
   always_comb begin
      logic [2:0] lane;
      for (int l = 0; l < NLANES; l++) begin
         lane = 3'(l);
         if (pop_ctrl.bps == BPS_QAM16) begin
            inc[l] = (lane[2] != pos_now[1]);
            cls[l] = lane[pos_now[0]];
         end else begin
            inc[l] = 1'b1;
            cls[l] = lane[pos_now];
         end
      end
   end

   // half minima over lanes 0-3 and 4-7
   always_comb begin
      m0lo_in = '1;
      m1lo_in = '1;
      m0hi_in = '1;
      m1hi_in = '1;
      for (int l = 0; l < NLANES / 2; l++) begin
         if (inc[l]) begin
            if (cls[l]) begin
               m1lo_in = (e[l] < m1lo_in) ? e[l] : m1lo_in;
            end else begin
               m0lo_in = (e[l] < m0lo_in) ? e[l] : m0lo_in;
            end
         end
         if (inc[l+NLANES/2]) begin
            if (cls[l+NLANES/2]) begin
               m1hi_in = (e[l+NLANES/2] < m1hi_in) ? e[l+NLANES/2] : m1hi_in;
            end else begin
               m0hi_in = (e[l+NLANES/2] < m0hi_in) ? e[l+NLANES/2] : m0hi_in;
            end
         end
      end
   end

   // linear rule operands and denominator
   always_comb begin
      b1_ln_in  = (bidx_ff == 2'd0) ? pop_data[NLANES*NUM_W +: NUM_W]
                                    : pop_data[(NLANES+1)*NUM_W +: NUM_W];
      b1_neg_in = (bidx_ff == 2'd0) ? pop_ctrl.sgn_i : pop_ctrl.sgn_q;
      b1_den_in = is_lin ? DEN_WIDTH'(pop_ctrl.nv) : {pop_ctrl.nv, 5'b0};
   end

   // bit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         bidx_ff <= '0;
      end else if (pop_v && adv) begin
         bidx_ff <= last_now ? 2'd0 : bidx_ff + 2'd1;
      end
   end

   // divider steps, one quotient bit each
   always_comb begin
      logic [CW-1:0] dsh;
      logic [CW-1:0] dfull;
      for (int k = 0; k < QB; k++) begin
         dsh   = CW'(dv_den_ff[k]) << (QB - 1 - k);
         dv_q_in[k] = dv_q_ff[k];
         if (dv_r_ff[k] >= dsh) begin
            dv_r_in[k] = dv_r_ff[k] - dsh;
            dv_q_in[k][QB-1-k] = 1'b1;
         end else begin
            dv_r_in[k] = dv_r_ff[k];
         end
         dfull = CW'(dv_den_ff[k]) << QB;
         dv_sat_in[k] = (k == 0) ? (dv_r_ff[k] >= dfull) : dv_sat_ff[k];
      end
   end

   // rounding result saturated to the output width
   always_comb begin
      logic [QB-1:0] q;
      logic [QB-1:0] half;
      q    = dv_q_ff[QB];
      half = {1'b1, {(QB-1){1'b0}}};
      if (dv_neg_ff[QB]) begin
         out_llr_in = (dv_sat_ff[QB] || q > half) ? half : LLR_WIDTH'(~q + 1'b1);
      end else begin
         out_llr_in = (dv_sat_ff[QB] || q[QB-1]) ? ~half : q;
      end
   end

   // valids of the back pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         b3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         b1_v_ff    <= pop_v;
         b2_v_ff    <= b1_v_ff;
         b3_v_ff    <= b2_v_ff;
         dv_v_ff[0] <= b3_v_ff;
         for (int k = 0; k < QB; k++) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
         out_v_ff <= dv_v_ff[QB];
      end
   end

   // back pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         b1_lin_ff  <= is_lin;
         b1_pos_ff  <= pos_now;
         b1_last_ff <= last_now;
         b1_neg_ff  <= b1_neg_in;
         b1_ln_ff   <= b1_ln_in;
         b1_den_ff  <= b1_den_in;
         b1_m0lo_ff <= m0lo_in;
         b1_m1lo_ff <= m1lo_in;
         b1_m0hi_ff <= m0hi_in;
         b1_m1hi_ff <= m1hi_in;

         b2_lin_ff  <= b1_lin_ff;
         b2_pos_ff  <= b1_pos_ff;
         b2_last_ff <= b1_last_ff;
         b2_neg_ff  <= b1_neg_ff;
         b2_ln_ff   <= b1_ln_ff;
         b2_den_ff  <= b1_den_ff;
         b2_m0_ff   <= (b1_m0lo_ff < b1_m0hi_ff) ? b1_m0lo_ff : b1_m0hi_ff;
         b2_m1_ff   <= (b1_m1lo_ff < b1_m1hi_ff) ? b1_m1lo_ff : b1_m1hi_ff;

         b3_pos_ff  <= b2_pos_ff;
         b3_last_ff <= b2_last_ff;
         b3_den_ff  <= b2_den_ff;
         if (b2_lin_ff) begin
            b3_num_ff <= b2_ln_ff;
            b3_neg_ff <= b2_neg_ff;
         end else begin
            b3_num_ff <= (b2_m1_ff < b2_m0_ff) ? b2_m0_ff - b2_m1_ff : b2_m1_ff - b2_m0_ff;
            b3_neg_ff <= (b2_m1_ff < b2_m0_ff);
         end

         dv_r_ff[0]    <= CW'(b3_num_ff) + CW'(b3_den_ff >> 1);
         dv_q_ff[0]    <= '0;
         dv_sat_ff[0]  <= 1'b0;
         dv_den_ff[0]  <= b3_den_ff;
         dv_neg_ff[0]  <= b3_neg_ff;
         dv_pos_ff[0]  <= b3_pos_ff;
         dv_last_ff[0] <= b3_last_ff;
         for (int k = 0; k < QB; k++) begin
            dv_r_ff[k+1]    <= dv_r_in[k];
            dv_q_ff[k+1]    <= dv_q_in[k];
            dv_sat_ff[k+1]  <= dv_sat_in[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_pos_ff[k+1]  <= dv_pos_ff[k];
            dv_last_ff[k+1] <= dv_last_ff[k];
         end

         out_llr_ff  <= out_llr_in;
         out_pos_ff  <= dv_pos_ff[QB];
         out_last_ff <= dv_last_ff[QB];
      end
   end

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.llr          = out_llr_ff;
   assign rsp_ch.bit_position = out_pos_ff;
   assign rsp_ch.last         = out_last_ff;

endmodule
`default_nettype wire

// File: sv/sld_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sld_checker #(
   parameter int LLR_WIDTH = 16
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [LLR_WIDTH-1:0] rsp_llr,
   input wire logic [1:0]           rsp_pos,
   input wire logic                 rsp_last
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_llr) && $stable(rsp_pos))
      else $error("stalled result changed");

   // an item ends on bit 0 (search orders, bpsk) or bit 1 (qpsk)
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_pos == 2'd0 || rsp_pos == 2'd1))
      else $error("final soft bit at wrong position");

endmodule

bind soft_llr_demapper_top sld_checker #(.LLR_WIDTH(LLR_WIDTH)) u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_llr(rsp_ch.llr),
   .rsp_pos(rsp_ch.bit_position), .rsp_last(rsp_ch.last)
);
`default_nettype wire

// File: dv/soft_llr_demapper_top_tb.sv
`timescale 1ns / 1ps
module soft_llr_demapper_top_tb
   import sld_pkg::*;
();

   typedef struct packed {
      logic signed [15:0] rx_i;
      logic signed [15:0] rx_q;
      logic [15:0]        nvar;
   } point_type;

   typedef struct packed {
      logic signed [15:0] llr;
      logic [1:0]         bit_position;
      logic               last;
   } soft_bit_type;

   localparam int LIMIT = 400000;

   // order codes without a constellation
   localparam logic [BPS_WIDTH-1:0] BPS_NONE_0 = 3'd0;
   localparam logic [BPS_WIDTH-1:0] BPS_NONE_5 = 3'd5;
   localparam logic [BPS_WIDTH-1:0] BPS_NONE_6 = 3'd6;
   localparam logic [BPS_WIDTH-1:0] BPS_NONE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [BPS_WIDTH-1:0] csr_wdata = '0;

   sld_req_if #(.IQ_WIDTH(16)) req_ch ();
   sld_rsp_if #(.LLR_WIDTH(16)) rsp_ch ();

   soft_llr_demapper_top i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   point_type    pending_points[$];
   soft_bit_type expected_bits[$];
   logic [BPS_WIDTH-1:0] mode = BPS_RESET;
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   logic hold_sender = 1'b0;
   logic req_taken = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic add_point(input point_type p);
      pending_points = {pending_points, p};
   endtask

   task automatic add_bit(input soft_bit_type b);
      expected_bits = {expected_bits, b};
   endtask

   // rounded, signed, saturated quotient
   function automatic logic [15:0] round_sat(longint unsigned num, longint unsigned den,
                                             bit neg);
      longint unsigned q;
      q = (num + den / 2) / den;
      if (neg) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
      return (q > 32767) ? 16'h7fff : 16'(q);
   endfunction

   function automatic longint unsigned abs64(longint x);
      return x < 0 ? longint'(-x) : longint'(x);
   endfunction

   // work out the soft bits of one point under the current mode
   task automatic predict_soft_bits(input point_type p);
      longint xi, xq, pr, pi;
      longint unsigned v, mn0, mn1, d, di, dq;
      longint unsigned dsq[16];
      int bps, m, pos, lbl;
      int psk_re[8] = '{4096, 2896, 0, -2896, -4096, -2896, 0, 2896};
      int psk_im[8] = '{0, 2896, 4096, 2896, 0, -2896, -4096, -2896};
      int psk_gray[8] = '{0, 1, 3, 2, 7, 6, 4, 5};
      int qam_lev[4] = '{-3886, -1295, 1295, 3886};
      int qam_gray[4] = '{0, 1, 3, 2};
      xi = p.rx_i;
      xq = p.rx_q;
      v = (p.nvar == 0) ? 1 : p.nvar;
      bps = mode;
      if (mode == BPS_BPSK || mode == BPS_QPSK) begin
         add_bit({round_sat(512 * abs64(xi), v, xi < 0), 2'd0, mode == BPS_BPSK});
         if (mode == BPS_QPSK)
            add_bit({round_sat(512 * abs64(xq), v, xq < 0), 2'd1, 1'b1});
         return;
      end
      if (mode != BPS_PSK8 && mode != BPS_QAM16) return;
      m = 1 << bps;
      for (int s = 0; s < m; s++) begin
         if (mode == BPS_PSK8) begin
            lbl = psk_gray[s];
            pr = psk_re[lbl];
            pi = psk_im[lbl];
         end else begin
            pr = qam_lev[qam_gray[(s >> 2) & 3]];
            pi = qam_lev[qam_gray[s & 3]];
         end
         di = abs64(xi - pr);
         dq = abs64(xq - pi);
         dsq[s] = di * di + dq * dq;
      end
      for (int b = 0; b < bps; b++) begin
         pos = bps - 1 - b;
         mn0 = '1;
         mn1 = '1;
         for (int s = 0; s < m; s++) begin
            d = dsq[s];
            if ((s >> pos) & 1) begin
               if (d < mn1) mn1 = d;
            end else if (d < mn0) mn0 = d;
         end
         add_bit({round_sat(mn1 < mn0 ? mn0 - mn1 : mn1 - mn0, 32 * v, mn1 < mn0),
                  2'(pos), b == bps - 1});
      end
   endtask

   // driver: bursts and gaps, inputs change on the falling edge
   initial begin
      req_ch.valid = 1'b0;
      req_ch.rx_i = '0;
      req_ch.rx_q = '0;
      req_ch.nvar = '0;
   end

   always @(negedge clock) begin
      logic send;
      send = 1'b0;
      if (!reset) begin
         if (req_taken) predict_soft_bits(pending_points.pop_front());
         if (!req_ch.valid || req_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_points.size() > 0 && !hold_sender) begin
               burst_left--;
               send = 1'b1;
               req_ch.rx_i <= pending_points[0].rx_i;
               req_ch.rx_q <= pending_points[0].rx_q;
               req_ch.nvar <= pending_points[0].nvar;
            end
            req_ch.valid <= send;
         end
      end
   end

   // receiver stall pattern
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      if ((cycles / 200) % 3 == 0) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
   end

   // monitor: sample on the rising edge
   always @(posedge clock) begin
      soft_bit_type got, want;
      cycles <= cycles + 1;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.llr, rsp_ch.bit_position, rsp_ch.last};
         if (expected_bits.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected soft bit %h", got);
         end else begin
            want = expected_bits.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch llr %0d/%0d pos %0d/%0d last %0d/%0d (exp/act)",
                           want.llr, got.llr, want.bit_position, got.bit_position,
                           want.last, got.last);
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic point_type rand_point();
      point_type p;
      p.rx_i = 16'($urandom);
      p.rx_q = 16'($urandom);
      p.nvar = 16'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            p.rx_i = $signed(16'($urandom_range(0, 9000))) - 16'sd4500;
            p.rx_q = $signed(16'($urandom_range(0, 9000))) - 16'sd4500;
            p.nvar = 16'($urandom_range(0, 2000));
         end
         1: p.nvar = 16'($urandom_range(0, 64));
         default: ;
      endcase
      return p;
   endfunction

   task automatic drain();
      wait (pending_points.size() == 0 && !req_ch.valid);
      wait (expected_bits.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_mode(input logic [BPS_WIDTH-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      mode = val;
   endtask

   initial begin
      logic [BPS_WIDTH-1:0] modes[10] = '{BPS_QPSK, BPS_BPSK, BPS_PSK8, BPS_QAM16,
                                          BPS_NONE_0, BPS_NONE_7, BPS_NONE_5, BPS_NONE_6,
                                          BPS_QAM16, BPS_PSK8};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // each mode in turn from the reset mode, with directed corners in the first four
      for (int ph = 0; ph < 10; ph++) begin
         if (ph > 0) write_mode(modes[ph]);
         if (ph < 4) begin
            add_point({16'sh7fff, 16'sh8000, 16'h0000});
            add_point({16'sh8000, 16'sh7fff, 16'hffff});
            add_point({16'sh0000, 16'sh0000, 16'h0001});
            add_point({16'sh1000, -16'sh1000, 16'h1000});
            add_point({16'sh050f, 16'shf2d2, 16'h0000});
         end
         for (int k = 0; k < ((ph < 4) ? 50 : ((ph > 7) ? 38 : 6)); k++)
            add_point(rand_point());
         // sender pauses mid-phase until every result is back
         if (ph == 0) begin
            wait (pending_points.size() < 30);
            hold_sender = 1'b1;
            wait (!req_ch.valid);
            wait (expected_bits.size() == 0);
            repeat (40) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_bits.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
